/* sv/bdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, codes and types for the bounded deque block.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEF = 256;   // default number of storage slots
   localparam int VAL_W     = 32;    // width of a stored word
   localparam int POS_W     = 8;     // width of the read index
   localparam int CSR_W     = 9;     // width of the limit and the reported count
   localparam int OP_W      = 3;
   localparam int ST_W      = 2;

   localparam logic [CSR_W-1:0] CAP_RESET = CSR_W'(256);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ_AT    = 3'd4,
      OP_READ_BACK  = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // access strobes from the controller to the storage
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_cmd_type;

endpackage : bdq_pkg
`default_nettype wire

/* sv/bdq_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: one deque operation per word.
// ----------------------------------------------------------------------------
interface bdq_req_if
   import bdq_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [VAL_W-1:0] push_value;
   logic [POS_W-1:0] position;

   modport source (output valid, operation, push_value, position, input ready);
   modport sink   (input valid, operation, push_value, position, output ready);
endinterface : bdq_req_if
`default_nettype wire

/* sv/bdq_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: value, status and resulting count per word.
// ----------------------------------------------------------------------------
interface bdq_rsp_if
   import bdq_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] read_value;
   logic [ST_W-1:0]  status;
   logic [CSR_W-1:0] entry_count;

   modport source (output valid, read_value, status, entry_count, input ready);
   modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface : bdq_rsp_if
`default_nettype wire

/* sv/bounded_deque_with_indexed_read.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bounded deque of 32-bit words in a circular single-port store with a head
// pointer and a count. Each request word (push front/back, pop front/back,
// read at an index from the front, read back) yields one response word with
// the value read, a status (ok, empty or index out of range, full) and the
// count after the operation. The accept cycle updates the pointers and makes
// the single memory access, and the next cycle loads the registered read data
// into the response register. The response register lets the next request in
// on the cycle the pending response is taken.
// csr_wr_data sets the capacity limit (reset 256); write it only while idle.
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read
// Top level: controller plus entry store.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_read
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   bdq_req_if.sink               req_chan,
   bdq_rsp_if.source             rsp_chan,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   localparam int PTR_W = $clog2(DEPTH);

   mem_cmd_type      mem_cmd;
   logic [PTR_W-1:0] mem_addr;
   logic [VAL_W-1:0] mem_wr_data;
   logic [VAL_W-1:0] mem_rd_data;

   bdq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   bdq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule : bounded_deque_with_indexed_read
`default_nettype wire

/* sv/bdq_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_mem
// Single-port entry store with registered read data.
// ----------------------------------------------------------------------------
module bdq_mem
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire mem_cmd_type                cmd,
   input  wire logic [$clog2(DEPTH)-1:0]   addr,
   input  wire logic [VAL_W-1:0]           wr_data,
   output logic      [VAL_W-1:0]           rd_data
);

   logic [VAL_W-1:0] store_mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         store_mem[addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= store_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bdq_mem
`default_nettype wire

/* sv/bdq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Head pointer, count and limit; drives the store and the response register.
// ----------------------------------------------------------------------------
module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   bdq_req_if.sink                         req_chan,
   bdq_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_W-1:0]           csr_wr_data,
   output mem_cmd_type                     mem_cmd,
   output logic      [$clog2(DEPTH)-1:0]   mem_addr,
   output logic      [VAL_W-1:0]           mem_wr_data,
   input  wire logic [VAL_W-1:0]           mem_rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int OFF_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic {
      S_IDLE,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CSR_W-1:0] limit_ff, limit_in;
   status_type       pend_status_ff, pend_status_in;
   logic             pend_rd_ff, pend_rd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ST_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [CSR_W-1:0] rsp_count_ff, rsp_count_in;

   logic             accept;
   op_type           op;
   logic             full;
   logic             empty;
   logic             in_range;
   logic [OFF_W-1:0] pos_ext;
   logic [OFF_W-1:0] cnt_ext;
   logic [CNT_W-1:0] count_m1;
   logic [PTR_W-1:0] off_sel;
   logic [PTR_W:0]   slot_sum;
   logic [PTR_W-1:0] slot;
   logic [PTR_W-1:0] head_inc;
   logic [PTR_W-1:0] head_dec;

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign op             = op_type'(req_chan.operation);

   // limits above the store depth behave as the depth itself
   assign full     = (CMP_W'(count_ff) >= CMP_W'(limit_ff)) || (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign pos_ext  = OFF_W'(req_chan.position);
   assign cnt_ext  = OFF_W'(count_ff);
   assign in_range = pos_ext < cnt_ext;
   assign count_m1 = count_ff - CNT_W'(1);

   assign head_inc = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_W'(1);
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - PTR_W'(1);

   always_comb begin
      unique case (op)
         OP_PUSH_BACK:              off_sel = count_ff[PTR_W-1:0];
         OP_POP_BACK, OP_READ_BACK: off_sel = count_m1[PTR_W-1:0];
         OP_READ_AT:                off_sel = pos_ext[PTR_W-1:0];
         default:                   off_sel = '0;
      endcase
   end

   // wrap head + offset into the store
   assign slot_sum = {1'b0, head_ff} + {1'b0, off_sel};
   assign slot     = (slot_sum >= DEPTH_SUM) ? PTR_W'(slot_sum - DEPTH_SUM)
                                             : slot_sum[PTR_W-1:0];

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      limit_in       = csr_wr_en ? csr_wr_data : limit_ff;
      pend_status_in = pend_status_ff;
      pend_rd_in     = pend_rd_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      mem_cmd        = '0;
      mem_addr       = slot;
      mem_wr_data    = req_chan.push_value;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         state_in       = S_RESP;
         pend_status_in = ST_OK;
         pend_rd_in     = 1'b0;
         unique case (op)
            OP_PUSH_FRONT: begin
               if (full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  mem_cmd.wr = 1'b1;
                  mem_addr   = head_dec;
                  head_in    = head_dec;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  mem_cmd.wr = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  mem_cmd.rd = 1'b1;
                  pend_rd_in = 1'b1;
                  head_in    = head_inc;
                  count_in   = count_m1;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  mem_cmd.rd = 1'b1;
                  pend_rd_in = 1'b1;
                  count_in   = count_m1;
               end
            end
            OP_READ_AT: begin
               if (!in_range) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  mem_cmd.rd = 1'b1;
                  pend_rd_in = 1'b1;
               end
            end
            OP_READ_BACK: begin
               if (empty) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  mem_cmd.rd = 1'b1;
                  pend_rd_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // read data is valid now; load the response word
      if (state_ff == S_RESP) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_value_in  = pend_rd_ff ? mem_rd_data : '0;
         rsp_status_in = pend_status_ff;
         rsp_count_in  = CSR_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_status_ff <= pend_status_in;
      pend_rd_ff     <= pend_rd_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule : bdq_ctrl
`default_nettype wire
